// ===== src/rc5_pkg.sv =====
package rc5_pkg;
    localparam int W = 16;
    localparam logic [W-1:0] MAGIC_P = 16'hb7e1;
    localparam logic [W-1:0] MAGIC_Q = 16'h9e37;
    localparam logic OP_ENC = 1'b0;
    localparam logic OP_DEC = 1'b1;
    typedef logic [W-1:0] t_word;

    function automatic t_word rotl(input t_word x, input logic [3:0] n);
        logic [2*W-1:0] d;
        d = {x, x} << n;
        return d[2*W-1:W];
    endfunction

    function automatic t_word rotr(input t_word x, input logic [3:0] n);
        logic [2*W-1:0] d;
        d = {x, x} >> n;
        return d[W-1:0];
    endfunction
endpackage

// ===== src/rc5_keysched.sv =====
module rc5_keysched #(
    parameter int ROUNDS    = 8,
    parameter int KEY_BYTES = 8,
    parameter int TBL_LEN   = 2 * (ROUNDS + 1)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_key_wr,
    input  logic [63:0]              i_key,
    output rc5_pkg::t_word           o_rk [TBL_LEN],
    output logic                     o_busy
);
    import rc5_pkg::*;
    localparam int KW_LEN  = (KEY_BYTES + 1) / 2;
    localparam int MIX_LEN = 3 * (TBL_LEN > KW_LEN ? TBL_LEN : KW_LEN);
    localparam int IW = $clog2(TBL_LEN + 1);
    localparam int JW = (KW_LEN > 1) ? $clog2(KW_LEN) : 1;
    localparam int KW = $clog2(MIX_LEN + 1);

    t_word r_s [TBL_LEN];
    t_word r_l [KW_LEN];
    t_word r_a, r_b;
    logic [IW-1:0] r_i;
    logic [JW-1:0] r_j;
    logic [KW-1:0] r_k;
    logic r_busy;
    t_word n_a, n_b, idx_s, idx_l;

    always_comb begin
        idx_s = r_s[r_i[IW-1:0]];
        idx_l = r_l[r_j];
        n_a = rotl(idx_s + r_a + r_b, 4'd3);
        n_b = rotl(idx_l + n_a + r_b, n_a[3:0] + r_b[3:0]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_key_wr) begin
            r_busy <= 1'b1;
            r_a <= '0;
            r_b <= '0;
            r_i <= '0;
            r_j <= '0;
            r_k <= '0;
            for (int t = 0; t < TBL_LEN; t++)
                r_s[t] <= MAGIC_P + t_word'(t) * MAGIC_Q;
            for (int t = 0; t < KW_LEN; t++)
                r_l[t] <= {(2*t+1 < KEY_BYTES) ? i_key[8*(2*t+1) +: 8] : 8'h00,
                           i_key[16*t +: 8]};
        end else if (r_busy) begin
            r_s[r_i] <= n_a;
            r_l[r_j] <= n_b;
            r_a <= n_a;
            r_b <= n_b;
            r_i <= (r_i == IW'(TBL_LEN - 1)) ? '0 : r_i + 1'b1;
            r_j <= (r_j == JW'(KW_LEN - 1)) ? '0 : r_j + 1'b1;
            r_k <= r_k + 1'b1;
            if (r_k == KW'(MIX_LEN - 1)) r_busy <= 1'b0;
        end
    end

    assign o_rk   = r_s;
    assign o_busy = r_busy;
endmodule

// ===== src/rc5_round.sv =====
module rc5_round (
    input  logic           i_clk,
    input  logic           i_en,
    input  logic           i_op,
    input  rc5_pkg::t_word i_a,
    input  rc5_pkg::t_word i_b,
    input  rc5_pkg::t_word i_ka,
    input  rc5_pkg::t_word i_kb,
    output logic           o_op,
    output rc5_pkg::t_word o_a,
    output rc5_pkg::t_word o_b
);
    import rc5_pkg::*;
    t_word n_a, n_b, ea, db;

    always_comb begin
        if (i_op == OP_ENC) begin
            ea  = rotl(i_a ^ i_b, i_b[3:0]) + i_ka;
            db  = '0;
            n_a = ea;
            n_b = rotl(i_b ^ ea, ea[3:0]) + i_kb;
        end else begin
            ea  = '0;
            db  = rotr(i_b - i_kb, i_a[3:0]) ^ i_a;
            n_b = db;
            n_a = rotr(i_a - i_ka, db[3:0]) ^ db;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_op <= i_op;
            o_a  <= n_a;
            o_b  <= n_b;
        end
    end
endmodule

// ===== src/rc5_block_cipher_unit.sv =====
// RC5-16/ROUNDS/KEY_BYTES ECB engine. Writing i_key_wr starts the key
// schedule sequencer; o_ready stays low while it runs. Data then flows
// through a pipeline of ROUNDS+2 register stages (input whitening, one
// stage per round, output whitening), accepting one block per cycle;
// back-pressure stalls the whole pipeline.
module rc5_block_cipher_unit #(
    parameter int ROUNDS    = 8,
    parameter int KEY_BYTES = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_key_wr,
    input  logic [63:0] i_key_value,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_op,
    input  logic [15:0] i_in_a,
    input  logic [15:0] i_in_b,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_out_a,
    output logic [15:0] o_out_b
);
    import rc5_pkg::*;
    localparam int TBL_LEN = 2 * (ROUNDS + 1);
    localparam int NS = ROUNDS + 2;

    t_word rk [TBL_LEN];
    logic  busy;
    logic  adv;
    logic  r_v [NS];
    logic  s_op [ROUNDS+1];
    t_word s_a [ROUNDS+1];
    t_word s_b [ROUNDS+1];
    t_word r_fa, r_fb;

    rc5_keysched #(.ROUNDS(ROUNDS), .KEY_BYTES(KEY_BYTES), .TBL_LEN(TBL_LEN)) u_ks (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_key_wr(i_key_wr),
        .i_key(i_key_value), .o_rk(rk), .o_busy(busy)
    );

    assign adv     = !r_v[NS-1] || i_ready;
    assign o_ready = adv && !busy;
    assign o_valid = r_v[NS-1];

    // stage 0: encrypt whitening; decrypt passes through
    always_ff @(posedge i_clk) begin
        if (adv) begin
            s_op[0] <= i_op;
            s_a[0]  <= (i_op == OP_ENC) ? i_in_a + rk[0] : i_in_a;
            s_b[0]  <= (i_op == OP_ENC) ? i_in_b + rk[1] : i_in_b;
        end
    end

    // encrypt uses rounds 1..R in order, decrypt R..1
    for (genvar g = 1; g <= ROUNDS; g++) begin : g_rnd
        t_word ka, kb;
        assign ka = (s_op[g-1] == OP_ENC) ? rk[2*g] : rk[2*(ROUNDS+1-g)];
        assign kb = (s_op[g-1] == OP_ENC) ? rk[2*g+1] : rk[2*(ROUNDS+1-g)+1];
        rc5_round u_r (
            .i_clk(i_clk), .i_en(adv), .i_op(s_op[g-1]),
            .i_a(s_a[g-1]), .i_b(s_b[g-1]), .i_ka(ka), .i_kb(kb),
            .o_op(s_op[g]), .o_a(s_a[g]), .o_b(s_b[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_fa  <= (s_op[ROUNDS] == OP_DEC) ? s_a[ROUNDS] - rk[0] : s_a[ROUNDS];
            r_fb  <= (s_op[ROUNDS] == OP_DEC) ? s_b[ROUNDS] - rk[1] : s_b[ROUNDS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int t = 0; t < NS; t++) r_v[t] <= 1'b0;
        end else if (adv) begin
            r_v[0] <= i_valid && !busy;
            for (int t = 1; t < NS; t++) r_v[t] <= r_v[t-1];
        end
    end

    assign o_out_a = r_fa;
    assign o_out_b = r_fb;
endmodule
